// ===== src/arp_pkg.sv =====
// types and constants for the aarch64 relocation patcher
package arp_pkg;

	localparam logic [3:0] OP_NONE       = 4'd0;
	localparam logic [3:0] OP_ABS64      = 4'd1;
	localparam logic [3:0] OP_ABS32      = 4'd2;
	localparam logic [3:0] OP_ABS16      = 4'd3;
	localparam logic [3:0] OP_ADD_LO12   = 4'd4;
	localparam logic [3:0] OP_LDST8_LO12 = 4'd5;
	localparam logic [3:0] OP_LDST16_LO12 = 4'd6;
	localparam logic [3:0] OP_LDST32_LO12 = 4'd7;
	localparam logic [3:0] OP_LDST64_LO12 = 4'd8;
	localparam logic [3:0] OP_ADRP       = 4'd9;
	localparam logic [3:0] OP_ADRP_NC    = 4'd10;
	localparam logic [3:0] OP_JUMP26     = 4'd11;
	localparam logic [3:0] OP_CALL26     = 4'd12;
	localparam logic [3:0] OP_PREL64     = 4'd13;
	localparam logic [3:0] OP_PREL32     = 4'd14;
	localparam logic [3:0] OP_PREL16     = 4'd15;

	localparam logic [1:0] WW_NONE = 2'd0;
	localparam logic [1:0] WW_16   = 2'd1;
	localparam logic [1:0] WW_32   = 2'd2;
	localparam logic [1:0] WW_64   = 2'd3;

	typedef struct packed {
		logic [3:0]         op;
		logic [63:0]        place_offset;
		logic [63:0]        symbol_value;
		logic signed [63:0] addend;
		logic               symbol_found;
		logic [63:0]        old_word;
	} req_t;

	typedef struct packed {
		logic [63:0] new_word;
		logic [1:0]  write_width;
		logic        error;
	} rsp_t;

endpackage

// ===== src/aarch64_relocation_patcher.sv =====
// aarch64 rela relocation patcher, two-stage pipeline
// One relocation per clock: busy is never asserted, so a transaction is taken
// whenever start is high. The result is registered after stage two, with a
// one-cycle done strobe; the receiver cannot stall it. Stage one forms the
// place address (load_base + place_offset) and S + A, stage two does the
// pc-relative subtract, range and alignment checks and the instruction merge.
// load_base must only be written while no transaction is in flight.
module aarch64_relocation_patcher (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [63:0]     cfg_data,
	input  logic            start,
	output logic            busy,
	input  arp_pkg::req_t   req,
	output logic            done,
	output arp_pkg::rsp_t   rsp
);
	import arp_pkg::*;

	logic [63:0] load_base_q;

	logic        valid_s1;
	logic [3:0]  op_s1;
	logic [63:0] place_s1;
	logic [63:0] sa_s1;
	logic        found_s1;
	logic [31:0] insn_s1;

	logic        done_q;
	rsp_t        rsp_q;

	logic [63:0] x;
	logic [63:0] d;
	logic [11:0] imm12;
	logic        misalign;
	logic [31:0] insn_lo12;
	logic [31:0] insn_adrp;
	logic [31:0] insn_br;
	logic        adrp_ok;
	logic        br_ok;
	logic        prel32_ok;
	logic        prel16_ok;
	logic [63:0] word;
	logic [1:0]  width;
	logic        err;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_base_q <= '0;
		end else if (cfg_we) begin
			load_base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			done_q   <= valid_s1;
		end
	end

	// stage one: place and s + a
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1    <= req.op;
			place_s1 <= load_base_q + req.place_offset;
			sa_s1    <= req.symbol_value + $unsigned(req.addend);
			found_s1 <= req.symbol_found;
			insn_s1  <= req.old_word[31:0];
		end
	end

	// stage two: checks and merge
	always_comb begin
		x = sa_s1 - place_s1;
		d = {12'd0, sa_s1[63:12]} - {12'd0, place_s1[63:12]};

		misalign = 1'b0;
		imm12    = sa_s1[11:0];
		unique case (op_s1)
			OP_LDST16_LO12: begin
				misalign = sa_s1[0];
				imm12    = {1'b0, sa_s1[11:1]};
			end
			OP_LDST32_LO12: begin
				misalign = |sa_s1[1:0];
				imm12    = {2'b0, sa_s1[11:2]};
			end
			OP_LDST64_LO12: begin
				misalign = |sa_s1[2:0];
				imm12    = {3'b0, sa_s1[11:3]};
			end
			default: begin
				misalign = 1'b0;
				imm12    = sa_s1[11:0];
			end
		endcase
		insn_lo12 = {insn_s1[31:22], imm12, insn_s1[9:0]};
		insn_adrp = {insn_s1[31], d[1:0], insn_s1[28:24], d[20:2], insn_s1[4:0]};
		insn_br   = {insn_s1[31:26], x[27:2]};

		adrp_ok   = (d[63:20] == '0) || (d[63:20] == '1);
		br_ok     = (x[1:0] == 2'b00) && ((x[63:27] == '0) || (x[63:27] == '1));
		prel32_ok = (x[63:32] == '0) || (x[63:31] == '1);
		prel16_ok = (x[63:16] == '0) || (x[63:15] == '1);

		word  = '0;
		width = WW_NONE;
		err   = 1'b0;
		if (op_s1 == OP_NONE) begin
			err = 1'b0;
		end else if (!found_s1) begin
			err = 1'b1;
		end else begin
			unique case (op_s1)
				OP_ABS64: begin
					word  = sa_s1;
					width = WW_64;
				end
				OP_ABS32: begin
					word  = {32'd0, sa_s1[31:0]};
					width = WW_32;
				end
				OP_ABS16: begin
					word  = {48'd0, sa_s1[15:0]};
					width = WW_16;
				end
				OP_ADD_LO12, OP_LDST8_LO12, OP_LDST16_LO12, OP_LDST32_LO12,
				OP_LDST64_LO12: begin
					err   = misalign;
					word  = {32'd0, insn_lo12};
					width = WW_32;
				end
				OP_ADRP: begin
					err   = !adrp_ok;
					word  = {32'd0, insn_adrp};
					width = WW_32;
				end
				OP_ADRP_NC: begin
					word  = {32'd0, insn_adrp};
					width = WW_32;
				end
				OP_JUMP26, OP_CALL26: begin
					err   = !br_ok;
					word  = {32'd0, insn_br};
					width = WW_32;
				end
				OP_PREL64: begin
					word  = x;
					width = WW_64;
				end
				OP_PREL32: begin
					err   = !prel32_ok;
					word  = {32'd0, x[31:0]};
					width = WW_32;
				end
				OP_PREL16: begin
					err   = !prel16_ok;
					word  = {48'd0, x[15:0]};
					width = WW_16;
				end
				default: begin
					word  = '0;
					width = WW_NONE;
				end
			endcase
		end
		if (err) begin
			word  = '0;
			width = WW_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q.new_word    <= word;
			rsp_q.write_width <= width;
			rsp_q.error       <= err;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.error |-> rsp.write_width == WW_NONE && rsp.new_word == '0)
		else $error("error result carries a write");

	a_w32_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.write_width == WW_32 |-> rsp.new_word[63:32] == '0)
		else $error("32-bit result has upper bits set");

	a_w16_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.write_width == WW_16 |-> rsp.new_word[63:16] == '0)
		else $error("16-bit result has upper bits set");

	a_none_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && op_s1 == OP_NONE |=> done && !rsp.error && rsp.write_width == WW_NONE)
		else $error("type none produced a write or an error");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("result not delivered two cycles after transaction");

endmodule
